@@ hdl/cba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and constants for the contiguous block allocator.
// ----------------------------------------------------------------------------
package cba_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int OP_W              = 3;
    localparam int ENTRY_W           = 7;   // run length / request / count width
    localparam int INDEX_W           = 6;   // block index port width
    localparam int STATUS_W          = 2;
    localparam int COUNT_MAX         = 127;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 3'd0,
        OP_FREE  = 3'd1,
        OP_QUERY = 3'd2,
        OP_COUNT = 3'd3,
        OP_CLEAR = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_ZERO    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_RD,
        S_LEN,
        S_CLR
    } state_t;

    typedef struct packed {
        logic                 valid;
        status_t              status;
        logic [INDEX_W-1:0]   start;
        logic [ENTRY_W-1:0]   count;
    } res_t;

endpackage

@@ hdl/cba_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_ram
// Run table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cba_ram #(
    parameter int DEPTH = cba_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rd_en,
    input  logic [$clog2(DEPTH)-1:0]          rd_addr,
    output logic [cba_pkg::ENTRY_W-1:0]       rd_data,
    input  logic                              wr_en,
    input  logic [$clog2(DEPTH)-1:0]          wr_addr,
    input  logic [cba_pkg::ENTRY_W-1:0]       wr_data
);
    import cba_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/cba_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_ctrl
// Sequencer: scans, marks, clears and reads the run table one entry a cycle.
// ----------------------------------------------------------------------------
module cba_ctrl #(
    parameter int TABLE_ENTRIES = cba_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [cba_pkg::OP_W-1:0]            op,
    input  logic [cba_pkg::ENTRY_W-1:0]         request_count,
    input  logic [cba_pkg::INDEX_W-1:0]         block_index,
    output logic                                busy,
    output cba_pkg::res_t                       res,
    output logic                                rd_en,
    output logic [$clog2(TABLE_ENTRIES)-1:0]    rd_addr,
    input  logic [cba_pkg::ENTRY_W-1:0]         rd_data,
    output logic                                wr_en,
    output logic [$clog2(TABLE_ENTRIES)-1:0]    wr_addr,
    output logic [cba_pkg::ENTRY_W-1:0]         wr_data
);
    import cba_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [ENTRY_W-1:0] req_reg, req_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic               issue_reg, issue_next;
    logic               rdv_reg, rdv_next;
    logic [IDX_W-1:0]   rpos_reg, rpos_next;
    logic [CNT_W-1:0]   run_reg, run_next;
    logic [CMP_W-1:0]   rem_reg, rem_next;
    logic               report_reg, report_next;

    logic [CNT_W-1:0]   run_new;
    logic [CNT_W-1:0]   cnt_new;
    logic               entry_free;
    logic               idx_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_SWEEP;
            op_reg     <= OP_ALLOC;
            req_reg    <= '0;
            ptr_reg    <= '0;
            issue_reg  <= 1'b0;
            rdv_reg    <= 1'b0;
            rpos_reg   <= '0;
            run_reg    <= '0;
            rem_reg    <= '0;
            report_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            req_reg    <= req_next;
            ptr_reg    <= ptr_next;
            issue_reg  <= issue_next;
            rdv_reg    <= rdv_next;
            rpos_reg   <= rpos_next;
            run_reg    <= run_next;
            rem_reg    <= rem_next;
            report_reg <= report_next;
        end
    end

    assign entry_free = (rd_data == '0);
    assign run_new    = entry_free ? run_reg + 1'b1 : '0;
    assign cnt_new    = entry_free ? run_reg + 1'b1 : run_reg;
    assign idx_ok     = int'(block_index) < TABLE_ENTRIES;
    assign busy       = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        req_next    = req_reg;
        ptr_next    = ptr_reg;
        issue_next  = issue_reg;
        rdv_next    = 1'b0;
        rpos_next   = rpos_reg;
        run_next    = run_reg;
        rem_next    = rem_reg;
        report_next = report_reg;

        rd_en   = 1'b0;
        rd_addr = ptr_reg;
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = '0;

        res        = '0;
        res.status = ST_OK;

        case (state_reg)
            S_SWEEP:
            begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_IDX)
                begin
                    state_next  = S_IDLE;
                    res.valid   = report_reg;
                    report_next = 1'b0;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = op_t'(op);
                    req_next = request_count;
                    case (op_t'(op))
                        OP_ALLOC:
                        begin
                            if (request_count == '0)
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_ZERO;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                                ptr_next   = LAST_IDX;
                                issue_next = 1'b1;
                                run_next   = '0;
                            end
                        end
                        OP_COUNT:
                        begin
                            state_next = S_SCAN;
                            ptr_next   = LAST_IDX;
                            issue_next = 1'b1;
                            run_next   = '0;
                        end
                        OP_FREE, OP_QUERY:
                        begin
                            if (idx_ok)
                            begin
                                state_next = S_RD;
                                ptr_next   = IDX_W'(block_index);
                            end
                            else
                            begin
                                res.valid = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            state_next  = S_SWEEP;
                            ptr_next    = '0;
                            report_next = 1'b1;
                        end
                        default:
                        begin
                            res.valid = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // each read is evaluated in the cycle after it is issued
                rd_en     = issue_reg;
                rdv_next  = issue_reg;
                rpos_next = ptr_reg;
                if (issue_reg)
                begin
                    ptr_next = ptr_reg - 1'b1;
                    if (ptr_reg == '0)
                    begin
                        issue_next = 1'b0;
                    end
                end
                if (rdv_reg)
                begin
                    if (op_reg == OP_ALLOC)
                    begin
                        run_next = run_new;
                        if (CMP_W'(run_new) == CMP_W'(req_reg))
                        begin
                            state_next = S_MARK;
                            ptr_next   = rpos_reg;
                            rpos_next  = rpos_reg;
                            rem_next   = CMP_W'(req_reg);
                            issue_next = 1'b0;
                            rdv_next   = 1'b0;
                        end
                        else if (rpos_reg == '0)
                        begin
                            state_next = S_IDLE;
                            res.valid  = 1'b1;
                            res.status = ST_NOSPACE;
                        end
                    end
                    else
                    begin
                        run_next = cnt_new;
                        if (rpos_reg == '0)
                        begin
                            state_next = S_IDLE;
                            res.valid  = 1'b1;
                            if (CMP_W'(cnt_new) > CMP_W'(COUNT_MAX))
                            begin
                                res.count = ENTRY_W'(COUNT_MAX);
                            end
                            else
                            begin
                                res.count = ENTRY_W'(cnt_new);
                            end
                        end
                    end
                end
            end

            S_MARK:
            begin
                wr_en    = 1'b1;
                wr_data  = req_reg;
                ptr_next = ptr_reg + 1'b1;
                rem_next = rem_reg - 1'b1;
                if (rem_reg == CMP_W'(1))
                begin
                    state_next = S_IDLE;
                    res.valid  = 1'b1;
                    res.start  = INDEX_W'(rpos_reg);
                end
            end

            S_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_LEN;
            end

            S_LEN:
            begin
                req_next = rd_data;
                rem_next = CMP_W'(rd_data);
                if (op_reg == OP_QUERY || entry_free)
                begin
                    state_next = S_IDLE;
                    res.valid  = 1'b1;
                    res.count  = rd_data;
                end
                else
                begin
                    state_next = S_CLR;
                end
            end

            S_CLR:
            begin
                // clearing stops at the table end
                wr_en    = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                rem_next = rem_reg - 1'b1;
                if (rem_reg == CMP_W'(1) || ptr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                    res.valid  = 1'b1;
                    res.count  = req_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/contiguous_block_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_block_allocator
// Run-length status table allocator for a pool of TABLE_ENTRIES blocks.
//
// A request is taken when start is high and busy is low. Ops: allocate,
// free, query run length, count free entries, clear table. One result per
// request shows on status/start_index/count_out for a single cycle with
// done high; the receiver cannot stall it, so it must take it then.
// Steps per op, through the one table read port and the one write port:
//   allocate: a top-down scan until the run fits, then one write per marked block
//   free:     a read of the entry, then one write per cleared block; query: a read
//   count:    a scan of the whole table; clear table: a write to every entry
//   zero-size allocate, out-of-range index, unused op: answered with no table access
// One request is in flight at a time; busy is high while it runs.
// After reset the table is swept to zero with busy high;
// no result is given for that sweep.
// ----------------------------------------------------------------------------
module contiguous_block_allocator #(
    parameter int TABLE_ENTRIES = cba_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [cba_pkg::OP_W-1:0]        op,
    input  logic [cba_pkg::ENTRY_W-1:0]     request_count,
    input  logic [cba_pkg::INDEX_W-1:0]     block_index,
    output logic                            done,
    output logic [cba_pkg::STATUS_W-1:0]    status,
    output logic [cba_pkg::INDEX_W-1:0]     start_index,
    output logic [cba_pkg::ENTRY_W-1:0]     count_out
);
    import cba_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    res_t               res;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [INDEX_W-1:0]  start_reg;
    logic [ENTRY_W-1:0]  count_reg;

    cba_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .op            (op),
        .request_count (request_count),
        .block_index   (block_index),
        .busy          (busy),
        .res           (res),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    cba_ram #(
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            status_reg <= '0;
            start_reg  <= '0;
            count_reg  <= '0;
        end
        else
        begin
            done_reg <= res.valid;
            if (res.valid)
            begin
                status_reg <= res.status;
                start_reg  <= res.start;
                count_reg  <= res.count;
            end
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign start_index = start_reg;
    assign count_out   = count_reg;

    // result strobe only comes once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while sequencer busy");

    a_zero_req: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_ALLOC && request_count == '0)
            |=> (done && status == ST_ZERO))
        else $error("zero-size allocate not rejected at once");

    a_unused_op: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op > OP_CLEAR)
            |=> (done && status == ST_OK && count_out == '0 && start_index == '0))
        else $error("unused op gave a non-empty result");

    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (start_index == '0 && count_out == '0))
        else $error("failed allocate carries data");

endmodule

@@ tb/sv/cba_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_checker
// Watches the request and result ports of the contiguous block allocator.
// It keeps a shadow copy of the run-length table, works out the result of
// every accepted request, and compares each done result, field by field,
// with the oldest outstanding prediction. It hands the error count and the
// number of outstanding results to the testbench top.
// ----------------------------------------------------------------------------
module cba_checker #(
    parameter int TABLE_ENTRIES = cba_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [cba_pkg::OP_W-1:0]        op,
    input  logic [cba_pkg::ENTRY_W-1:0]     request_count,
    input  logic [cba_pkg::INDEX_W-1:0]     block_index,
    input  logic                            done,
    input  logic [cba_pkg::STATUS_W-1:0]    status,
    input  logic [cba_pkg::INDEX_W-1:0]     start_index,
    input  logic [cba_pkg::ENTRY_W-1:0]     count_out,
    output int                              fail_count,
    output int                              pending
);
    import cba_pkg::*;

    typedef struct packed {
        status_t              st;
        logic [INDEX_W-1:0]   first;
        logic [ENTRY_W-1:0]   cnt;
    } request_result_t;

    logic [ENTRY_W-1:0] run_len [TABLE_ENTRIES];
    request_result_t    expected_results [$];
    request_result_t    oldest;
    int                 errs = 0;

    // Applies one request to the shadow table and returns its result.
    function automatic request_result_t predict_request(
        input logic [OP_W-1:0]    code,
        input logic [ENTRY_W-1:0] req,
        input logic [INDEX_W-1:0] idx
    );
        request_result_t r;
        int run;
        int p;
        int k;
        int n;
        bit found;
        r.st    = ST_OK;
        r.first = '0;
        r.cnt   = '0;
        case (code)
            OP_ALLOC:
            begin
                if (req == '0)
                    r.st = ST_ZERO;
                else
                begin
                    // scan top down, mark the run upward from where it fits
                    run   = 0;
                    found = 1'b0;
                    for (p = TABLE_ENTRIES - 1; p >= 0 && !found; p--)
                    begin
                        if (run_len[p] == '0)
                            run++;
                        else
                            run = 0;
                        if (run == int'(req))
                        begin
                            for (k = 0; k < run; k++)
                                run_len[p + k] = req;
                            r.first = INDEX_W'(p);
                            found   = 1'b1;
                        end
                    end
                    if (!found)
                        r.st = ST_NOSPACE;
                end
            end
            OP_FREE:
            begin
                if (int'(idx) < TABLE_ENTRIES)
                begin
                    // length taken as is, even from inside a run
                    n = int'(run_len[idx]);
                    for (k = 0; k < n && int'(idx) + k < TABLE_ENTRIES; k++)
                        run_len[int'(idx) + k] = '0;
                    r.cnt = ENTRY_W'(n);
                end
            end
            OP_QUERY:
            begin
                if (int'(idx) < TABLE_ENTRIES)
                    r.cnt = run_len[idx];
            end
            OP_COUNT:
            begin
                n = 0;
                for (p = 0; p < TABLE_ENTRIES; p++)
                    if (run_len[p] == '0)
                        n++;
                if (n > COUNT_MAX)
                    n = COUNT_MAX;
                r.cnt = ENTRY_W'(n);
            end
            OP_CLEAR:
            begin
                for (p = 0; p < TABLE_ENTRIES; p++)
                    run_len[p] = '0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_error(input string what, input int want, input int got);
        errs++;
        if (errs <= 10)
            $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            for (int i = 0; i < TABLE_ENTRIES; i++)
                run_len[i] = '0;
            pending <= 0;
        end
        else
        begin
            // results first: a new request at this edge cannot be the one done now
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_error("result with no request outstanding", 0, 1);
                else
                begin
                    oldest = expected_results.pop_front();
                    if (status !== oldest.st)
                        report_error("status", int'(oldest.st), int'(status));
                    if (start_index !== oldest.first)
                        report_error("start_index", int'(oldest.first), int'(start_index));
                    if (count_out !== oldest.cnt)
                        report_error("count_out", int'(oldest.cnt), int'(count_out));
                end
            end
            if (start && !busy)
                expected_results.push_back(predict_request(op, request_count, block_index));
            pending    <= expected_results.size();
            fail_count <= errs;
        end
    end

endmodule

@@ tb/sv/tb_contiguous_block_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contiguous_block_allocator
// Drives requests into the contiguous block allocator: a directed pass over
// the corner cases, then random bursts built mostly from allocate and free
// pairs, with random gaps and drain pauses. The checker beside the block
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_contiguous_block_allocator;
    import cba_pkg::*;

    localparam int TBL_N        = TABLE_ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 400;
    localparam int IDLE_LIMIT   = 4000;

    // op codes the block does not define
    localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   start         = 1'b0;
    logic [OP_W-1:0]        op            = '0;
    logic [ENTRY_W-1:0]     request_count = '0;
    logic [INDEX_W-1:0]     block_index   = '0;
    logic                   busy;
    logic                   done;
    logic [STATUS_W-1:0]    status;
    logic [INDEX_W-1:0]     start_index;
    logic [ENTRY_W-1:0]     count_out;

    int                     fail_count;
    int                     pending;
    int                     idle_cycles = 0;
    logic [OP_W-1:0]        inflight_op = '0;
    logic [INDEX_W-1:0]     live_starts [$];

    contiguous_block_allocator #(
        .TABLE_ENTRIES (TBL_N)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .request_count (request_count),
        .block_index   (block_index),
        .done          (done),
        .status        (status),
        .start_index   (start_index),
        .count_out     (count_out)
    );

    cba_checker #(
        .TABLE_ENTRIES (TBL_N)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .request_count (request_count),
        .block_index   (block_index),
        .done          (done),
        .status        (status),
        .start_index   (start_index),
        .count_out     (count_out),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Presents one request and holds it until the block takes it.
    // start is left high; the caller lowers it at the end of a burst.
    task automatic issue(input logic [OP_W-1:0] code, input int req, input int idx);
        start         <= 1'b1;
        op            <= code;
        request_count <= ENTRY_W'(req);
        block_index   <= INDEX_W'(idx);
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic issue_random;
        int pick;
        int r;
        int j;
        logic [INDEX_W-1:0] at;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                issue(OP_ALLOC, 0, $urandom_range(0, 63));
            else if (r < 80)
                issue(OP_ALLOC, $urandom_range(1, 8), $urandom_range(0, 63));
            else if (r < 93)
                issue(OP_ALLOC, $urandom_range(9, TBL_N), $urandom_range(0, 63));
            else
                issue(OP_ALLOC, $urandom_range(TBL_N + 1, 127), $urandom_range(0, 63));
        end
        else if (pick < 75)
        begin
            if (live_starts.size() != 0 && $urandom_range(0, 9) < 7)
            begin
                j  = $urandom_range(0, live_starts.size() - 1);
                at = live_starts[j];
                live_starts.delete(j);
                issue(OP_FREE, $urandom_range(0, 127), int'(at));
            end
            else
                issue(OP_FREE, $urandom_range(0, 127), $urandom_range(0, 63));
        end
        else if (pick < 85)
            issue(OP_QUERY, $urandom_range(0, 127), $urandom_range(0, 63));
        else if (pick < 93)
            issue(OP_COUNT, $urandom_range(0, 127), $urandom_range(0, 63));
        else if (pick < 97)
        begin
            live_starts.delete();
            issue(OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 63));
        end
        else
            issue(OP_SPARE5 + OP_W'($urandom_range(0, 2)),
                  $urandom_range(0, 127), $urandom_range(0, 63));
    endtask

    // remember where allocations landed so frees can target run starts
    always @(posedge clk)
    begin
        if (done && inflight_op == OP_ALLOC && status == ST_OK)
            live_starts.push_back(start_index);
        if (start && !busy)
            inflight_op = op;
    end

    // watchdog on cycles with no request and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_contiguous_block_allocator failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int sent;
        int burst;
        int gap;
        int bursts_done;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass
        issue(OP_COUNT, 0, 0);
        issue(OP_ALLOC, 0, 63);             // zero-size request
        issue(OP_ALLOC, TBL_N, 0);          // whole table
        issue(OP_COUNT, 127, 63);
        issue(OP_ALLOC, 1, 0);              // no room
        issue(OP_QUERY, 0, 0);
        issue(OP_QUERY, 0, 63);
        issue(OP_FREE, 0, 0);
        issue(OP_ALLOC, 127, 0);            // larger than the table
        issue(OP_ALLOC, TBL_N + 1, 0);
        issue(OP_ALLOC, 1, 0);
        issue(OP_ALLOC, 3, 0);
        issue(OP_FREE, 0, 61);              // free from inside a run
        issue(OP_QUERY, 0, 60);
        issue(OP_QUERY, 0, 63);
        issue(OP_SPARE5, 127, 63);
        issue(OP_SPARE6, 64, 32);
        issue(OP_SPARE7, 1, 1);
        issue(OP_CLEAR, 127, 63);
        issue(OP_COUNT, 0, 0);
        issue(OP_FREE, 0, 63);              // free of a free entry
        issue(OP_ALLOC, 2, 0);
        issue(OP_FREE, 0, 63);              // clearing runs off the table end
        issue(OP_COUNT, 0, 0);
        start <= 1'b0;
        drain();

        // random bursts
        sent        = 0;
        bursts_done = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                issue_random();
                sent++;
            end
            bursts_done++;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (bursts_done % 9 == 0)
            begin
                start <= 1'b0;
                drain();
            end
            else if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        start <= 1'b0;
        drain();
        repeat (3 * TBL_N) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb_contiguous_block_allocator passed");
        else
            $display("tb_contiguous_block_allocator failed");
        $finish;
    end

endmodule
